// File: rtl/msr_pkg.sv
`timescale 1ns / 1ps

package msr_pkg;

  localparam int unsigned CfgDataWidth = 24;
  localparam int unsigned FifoDepth    = 4;
  localparam int unsigned FifoPtrWidth = $clog2(FifoDepth);
  localparam int unsigned FifoCntWidth = $clog2(FifoDepth + 1);

  // Register indexes on the configuration port.
  localparam logic CfgPduCapacity  = 1'b0;
  localparam logic CfgTimeoutTicks = 1'b1;

  localparam logic [15:0] PduCapacityReset  = 16'd1024;
  localparam logic [23:0] TimeoutTicksReset = 24'd20000;

  // Input item operations.
  localparam logic OpByte = 1'b0;
  localparam logic OpTick = 1'b1;

  // Segmentation codes from the top two bits of a fragment header.
  localparam logic [1:0] SarComplete = 2'd0;
  localparam logic [1:0] SarFirst    = 2'd1;
  localparam logic [1:0] SarCont     = 2'd2;
  localparam logic [1:0] SarLast     = 2'd3;

  // Result kinds.
  localparam logic [2:0] KindPayload  = 3'd0;
  localparam logic [2:0] KindDone     = 3'd1;
  localparam logic [2:0] KindRefused  = 3'd2;
  localparam logic [2:0] KindTimeout  = 3'd3;
  localparam logic [2:0] KindOverflow = 3'd4;

  // Refusal reasons.
  localparam logic [1:0] ErrCompletePending = 2'd0;
  localparam logic [1:0] ErrFirstPending    = 2'd1;
  localparam logic [1:0] ErrNoPrior         = 2'd2;
  localparam logic [1:0] ErrTypeMismatch    = 2'd3;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  payload;
    logic [5:0]  pdu_type;
    logic [15:0] pdu_length;
    logic [1:0]  error_code;
    logic        last;
  } result_t;

  // Up to two results produced by one accepted item.
  typedef struct packed {
    result_t    res0;
    result_t    res1;
    logic [1:0] num;
  } step_out_t;

endpackage

// File: rtl/mesh_proxy_sar_reassembler_core.sv
`timescale 1ns / 1ps
// Results of an item are written to the result queue at its transfer and shown from there.
// Throughput: one item per cycle, stalled while the four-entry result queue lacks room
// for two results; the single-result output port shows an item's results one at a time.
// Reset (asynchronous, active low) empties the queue, clears the reassembly and
// timer state, and loads the default capacity and timeout registers.
module mesh_proxy_sar_reassembler_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic                              cfg_index_i,
  input  logic [msr_pkg::CfgDataWidth-1:0]  cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              op_i,
  input  logic [7:0]                        data_i,
  input  logic                              frag_end_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [2:0]                        kind_o,
  output logic [7:0]                        payload_o,
  output logic [5:0]                        pdu_type_o,
  output logic [15:0]                       pdu_length_o,
  output logic [1:0]                        error_code_o,
  output logic                              last_o
);
  import msr_pkg::*;

  step_out_t step;
  result_t   head;
  logic      accept;
  logic      full2;

  assign in_stall_o = full2;
  assign accept     = in_valid_i && !full2;

  msr_step u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .op_i        (op_i),
    .data_i      (data_i),
    .frag_end_i  (frag_end_i),
    .step_o      (step)
  );

  msr_out_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (step),
    .pop_i   (out_valid_o && !out_stall_i),
    .full2_o (full2),
    .valid_o (out_valid_o),
    .head_o  (head)
  );

  assign kind_o       = head.kind;
  assign payload_o    = head.payload;
  assign pdu_type_o   = head.pdu_type;
  assign pdu_length_o = head.pdu_length;
  assign error_code_o = head.error_code;
  assign last_o       = head.last;

endmodule

// File: rtl/msr_step.sv
`timescale 1ns / 1ps

module msr_step (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic                                cfg_index_i,
  input  logic [msr_pkg::CfgDataWidth-1:0]    cfg_data_i,
  input  logic                                accept_i,
  input  logic                                op_i,
  input  logic [7:0]                          data_i,
  input  logic                                frag_end_i,
  output msr_pkg::step_out_t                  step_o
);
  import msr_pkg::*;

  logic [15:0] pdu_capacity_q;
  logic [23:0] timeout_ticks_q;

  logic        in_fragment_q, in_fragment_d;
  logic        frag_accepted_q, frag_accepted_d;
  logic [1:0]  frag_code_q, frag_code_d;
  logic [5:0]  cur_type_q, cur_type_d;
  logic [15:0] pending_len_q, pending_len_d;
  logic        timer_run_q, timer_run_d;
  logic [23:0] timer_cnt_q, timer_cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pdu_capacity_q  <= PduCapacityReset;
      timeout_ticks_q <= TimeoutTicksReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgPduCapacity:  pdu_capacity_q  <= cfg_data_i[15:0];
        CfgTimeoutTicks: timeout_ticks_q <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [1:0]  hdr_code;
    logic [5:0]  hdr_type;
    logic        refuse;
    logic [1:0]  err;
    logic [23:0] cnt_inc;
    result_t     r0;
    result_t     r1;
    logic [1:0]  n;

    in_fragment_d   = in_fragment_q;
    frag_accepted_d = frag_accepted_q;
    frag_code_d     = frag_code_q;
    cur_type_d      = cur_type_q;
    pending_len_d   = pending_len_q;
    timer_run_d     = timer_run_q;
    timer_cnt_d     = timer_cnt_q;

    hdr_code = data_i[7:6];
    hdr_type = data_i[5:0];
    refuse   = 1'b0;
    err      = ErrCompletePending;
    cnt_inc  = timer_cnt_q + 24'd1;
    r0       = '0;
    r1       = '0;
    n        = 2'd0;

    if (op_i == OpTick) begin
      if (timer_run_q) begin
        timer_cnt_d = cnt_inc;
        if (cnt_inc >= timeout_ticks_q) begin
          r0.kind       = KindTimeout;
          r0.pdu_type   = cur_type_q;
          r0.pdu_length = pending_len_q;
          n             = 2'd1;
          pending_len_d = '0;
          timer_run_d   = 1'b0;
          timer_cnt_d   = '0;
          if (in_fragment_q) begin
            frag_accepted_d = 1'b0;
          end
        end
      end
    end else begin
      if (!in_fragment_q) begin
        if (hdr_code == SarComplete || hdr_code == SarFirst) begin
          if (pending_len_q != 16'd0) begin
            refuse = 1'b1;
            err    = (hdr_code == SarComplete) ? ErrCompletePending : ErrFirstPending;
          end
        end else if (pending_len_q == 16'd0) begin
          refuse = 1'b1;
          err    = ErrNoPrior;
        end else if (hdr_type != cur_type_q) begin
          refuse = 1'b1;
          err    = ErrTypeMismatch;
        end

        if (refuse) begin
          r0.kind         = KindRefused;
          r0.pdu_type     = hdr_type;
          r0.pdu_length   = pending_len_q;
          r0.error_code   = err;
          n               = 2'd1;
          frag_accepted_d = 1'b0;
        end else begin
          frag_accepted_d = 1'b1;
          frag_code_d     = hdr_code;
          if (hdr_code == SarComplete || hdr_code == SarFirst) begin
            cur_type_d = hdr_type;
          end
          if (hdr_code == SarFirst || hdr_code == SarCont) begin
            timer_run_d = 1'b1;
            timer_cnt_d = '0;
          end else if (hdr_code == SarLast) begin
            timer_run_d = 1'b0;
            timer_cnt_d = '0;
          end
        end
        in_fragment_d = !frag_end_i;
      end else begin
        if (frag_accepted_q) begin
          if (pending_len_q < pdu_capacity_q) begin
            pending_len_d = pending_len_q + 16'd1;
            r0.kind       = KindPayload;
            r0.payload    = data_i;
            r0.pdu_type   = cur_type_q;
            r0.pdu_length = pending_len_d;
          end else begin
            r0.kind       = KindOverflow;
            r0.pdu_type   = cur_type_q;
            r0.pdu_length = pending_len_q;
          end
          n = 2'd1;
        end
        if (frag_end_i) begin
          in_fragment_d = 1'b0;
        end
      end

      // A complete or last fragment closes the PDU on its final byte.
      if (frag_end_i && frag_accepted_d &&
          (frag_code_d == SarComplete || frag_code_d == SarLast)) begin
        if (n == 2'd0) begin
          r0.kind       = KindDone;
          r0.pdu_type   = cur_type_d;
          r0.pdu_length = pending_len_d;
        end else begin
          r1.kind       = KindDone;
          r1.pdu_type   = cur_type_d;
          r1.pdu_length = pending_len_d;
        end
        n             = n + 2'd1;
        pending_len_d = '0;
      end
      if (frag_end_i) begin
        frag_accepted_d = 1'b0;
      end
    end

    if (n == 2'd1) begin
      r0.last = 1'b1;
    end else if (n == 2'd2) begin
      r1.last = 1'b1;
    end

    step_o.res0 = r0;
    step_o.res1 = r1;
    step_o.num  = accept_i ? n : 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_fragment_q   <= 1'b0;
      frag_accepted_q <= 1'b0;
      frag_code_q     <= SarComplete;
      cur_type_q      <= '0;
      pending_len_q   <= '0;
      timer_run_q     <= 1'b0;
      timer_cnt_q     <= '0;
    end else if (accept_i) begin
      in_fragment_q   <= in_fragment_d;
      frag_accepted_q <= frag_accepted_d;
      frag_code_q     <= frag_code_d;
      cur_type_q      <= cur_type_d;
      pending_len_q   <= pending_len_d;
      timer_run_q     <= timer_run_d;
      timer_cnt_q     <= timer_cnt_d;
    end
  end

endmodule

// File: rtl/msr_out_fifo.sv
`timescale 1ns / 1ps

module msr_out_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  msr_pkg::step_out_t   push_i,
  input  logic                 pop_i,
  output logic                 full2_o,
  output logic                 valid_o,
  output msr_pkg::result_t     head_o
);
  import msr_pkg::*;

  result_t                 mem_q [FifoDepth];
  logic [FifoPtrWidth-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoCntWidth-1:0] count_q;
  logic [FifoPtrWidth-1:0] wr_ptr1;

  assign wr_ptr1 = wr_ptr_q + FifoPtrWidth'(1);
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  // Room for two results is needed before the next item can enter.
  assign full2_o = (count_q > FifoCntWidth'(FifoDepth - 2));

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.res0;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_ptr1] <= push_i.res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + FifoPtrWidth'(push_i.num);
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + FifoPtrWidth'(1);
      end
      count_q <= count_q + FifoCntWidth'(push_i.num) - FifoCntWidth'(pop_i);
    end
  end

endmodule

// File: sim/mesh_proxy_sar_reassembler_core_test.sv
`timescale 1ns / 1ps

module mesh_proxy_sar_reassembler_core_test;
  import msr_pkg::*;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic                    cfg_index_i;
  logic [CfgDataWidth-1:0] cfg_data_i;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic                    op_i;
  logic [7:0]              data_i;
  logic                    frag_end_i;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic [2:0]              kind_o;
  logic [7:0]              payload_o;
  logic [5:0]              pdu_type_o;
  logic [15:0]             pdu_length_o;
  logic [1:0]              error_code_o;
  logic                    last_o;

  mesh_proxy_sar_reassembler_core DUT (.*);

  // Shadow of the reassembly state, advanced on every input transfer.
  logic        frag_open;
  logic        frag_ok;
  logic [1:0]  frag_code;
  logic [5:0]  cur_type;
  logic [15:0] pend_len;
  logic        timer_on;
  logic [23:0] tick_count;
  logic [15:0] pdu_cap;
  logic [23:0] tmo_ticks;

  result_t results_due[$];
  int      mismatches = 0;
  int      bytes_sent = 0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("FAIL mesh_proxy_sar_reassembler_core");
    $finish;
  end

  always @(negedge clk_i) begin
    out_stall_i <= (recv_idle_pct != 0) && ($urandom_range(0, 99) < recv_idle_pct);
  end

  function automatic void add_result(logic [2:0] kind, logic [7:0] pay, logic [5:0] typ,
                                     logic [15:0] len, logic [1:0] err);
    result_t r;
    r = '{kind: kind, payload: pay, pdu_type: typ, pdu_length: len, error_code: err,
          last: 1'b0};
    results_due.push_back(r);
  endfunction

  function automatic void reassemble_step(logic op, logic [7:0] data, logic fend);
    int unsigned before_n;
    logic [1:0]  code;
    logic [5:0]  typ;
    logic        refused;
    logic [1:0]  err;
    result_t     tail;
    before_n = results_due.size();
    if (op == OpTick) begin
      if (timer_on) begin
        tick_count = tick_count + 24'd1;
        if (tick_count >= tmo_ticks) begin
          add_result(KindTimeout, 8'd0, cur_type, pend_len, 2'd0);
          pend_len = 16'd0;
          timer_on = 1'b0;
          tick_count = 24'd0;
          if (frag_open) frag_ok = 1'b0;
        end
      end
    end else begin
      if (!frag_open) begin
        code = data[7:6];
        typ = data[5:0];
        refused = 1'b0;
        err = ErrCompletePending;
        if (code == SarComplete || code == SarFirst) begin
          if (pend_len != 16'd0) begin
            refused = 1'b1;
            err = (code == SarComplete) ? ErrCompletePending : ErrFirstPending;
          end
        end else if (pend_len == 16'd0) begin
          refused = 1'b1;
          err = ErrNoPrior;
        end else if (typ != cur_type) begin
          refused = 1'b1;
          err = ErrTypeMismatch;
        end
        if (refused) begin
          add_result(KindRefused, 8'd0, typ, pend_len, err);
          frag_ok = 1'b0;
        end else begin
          frag_ok = 1'b1;
          frag_code = code;
          if (code == SarComplete || code == SarFirst) cur_type = typ;
          if (code == SarFirst || code == SarCont) begin
            timer_on = 1'b1;
            tick_count = 24'd0;
          end else if (code == SarLast) begin
            timer_on = 1'b0;
            tick_count = 24'd0;
          end
        end
        frag_open = !fend;
      end else begin
        if (frag_ok) begin
          if (pend_len < pdu_cap) begin
            pend_len = pend_len + 16'd1;
            add_result(KindPayload, data, cur_type, pend_len, 2'd0);
          end else begin
            add_result(KindOverflow, 8'd0, cur_type, pend_len, 2'd0);
          end
        end
        if (fend) frag_open = 1'b0;
      end
      if (fend && frag_ok && (frag_code == SarComplete || frag_code == SarLast)) begin
        add_result(KindDone, 8'd0, cur_type, pend_len, 2'd0);
        pend_len = 16'd0;
      end
      if (fend) frag_ok = 1'b0;
    end
    if (results_due.size() > before_n) begin
      tail = results_due.pop_back();
      tail.last = 1'b1;
      results_due.push_back(tail);
    end
  endfunction

  function automatic void check_result();
    result_t got;
    result_t want;
    got = '{kind: kind_o, payload: payload_o, pdu_type: pdu_type_o,
            pdu_length: pdu_length_o, error_code: error_code_o, last: last_o};
    if (results_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: kind %0d payload %0d type %0d length %0d err %0d last %0d",
                 got.kind, got.payload, got.pdu_type, got.pdu_length, got.error_code,
                 got.last);
    end else begin
      want = results_due.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: kind %0d/%0d payload %0d/%0d type %0d/%0d length %0d/%0d ",
                    "err %0d/%0d last %0d/%0d (expected/actual)"},
                   want.kind, got.kind, want.payload, got.payload, want.pdu_type,
                   got.pdu_type, want.pdu_length, got.pdu_length, want.error_code,
                   got.error_code, want.last, got.last);
      end
    end
  endfunction

  // Results are checked before the same edge's input transfer is predicted, so a
  // prediction can never be matched in the cycle of its own transfer.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      frag_open = 1'b0;
      frag_ok = 1'b0;
      frag_code = SarComplete;
      cur_type = 6'd0;
      pend_len = 16'd0;
      timer_on = 1'b0;
      tick_count = 24'd0;
      pdu_cap = PduCapacityReset;
      tmo_ticks = TimeoutTicksReset;
    end else begin
      if (out_valid_o && !out_stall_i) check_result();
      if (cfg_we_i) begin
        if (cfg_index_i == CfgPduCapacity) pdu_cap = cfg_data_i[15:0];
        else tmo_ticks = cfg_data_i[23:0];
      end
      if (in_valid_i && !in_stall_o) reassemble_step(op_i, data_i, frag_end_i);
    end
  end

  task automatic send_item(input logic op, input logic [7:0] data, input logic fend);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    op_i = op;
    data_i = data;
    frag_end_i = fend;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_ticks(input int count);
    repeat (count) send_item(OpTick, 8'($urandom), 1'($urandom));
  endtask

  // Header followed by nbytes payload bytes; a tick now and then lands mid-fragment.
  task automatic send_fragment(input logic [7:0] header, input int nbytes);
    int k;
    send_item(OpByte, header, nbytes == 0);
    for (k = 1; k <= nbytes; k++) begin
      if ($urandom_range(0, 19) == 0) send_ticks(1);
      send_item(OpByte, 8'($urandom), k == nbytes);
    end
    bytes_sent += nbytes + 1;
  endtask

  // No register write may overlap work on an item, including items with no results.
  task automatic settle_idle();
    in_valid_i = 1'b0;
    while (results_due.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_cfg(input logic idx, input logic [CfgDataWidth-1:0] value);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic int rand_frag_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(6, 20) : $urandom_range(0, 5);
  endfunction

  task automatic test_header_checks();
    send_ticks(1);                  // timer not running yet
    send_item(OpByte, {SarComplete, 6'h3F}, 1'b1);
    send_item(OpByte, {SarComplete, 6'h00}, 1'b0);
    send_item(OpByte, 8'h00, 1'b0);
    send_item(OpByte, 8'hFF, 1'b1);
    send_item(OpByte, {SarCont, 6'h05}, 1'b0);
    send_item(OpByte, 8'h12, 1'b1);
    send_item(OpByte, {SarLast, 6'h01}, 1'b1);
    send_item(OpByte, {SarFirst, 6'h0A}, 1'b0);
    send_item(OpByte, 8'h11, 1'b1);
    send_item(OpByte, {SarComplete, 6'h0A}, 1'b1);
    send_item(OpByte, {SarFirst, 6'h0A}, 1'b1);
    send_item(OpByte, {SarCont, 6'h0B}, 1'b0);
    send_item(OpByte, 8'h77, 1'b1);
    send_item(OpByte, {SarCont, 6'h0A}, 1'b0);
    send_item(OpByte, 8'h22, 1'b1);
    send_ticks(1);
    send_item(OpByte, {SarLast, 6'h0A}, 1'b0);
    send_item(OpByte, 8'h33, 1'b1);
    // An empty first fragment starts the timer but leaves nothing pending.
    send_item(OpByte, {SarFirst, 6'h05}, 1'b1);
    send_item(OpByte, {SarCont, 6'h05}, 1'b1);
    settle_idle();
  endtask

  task automatic test_capacity_and_timeout();
    write_cfg(CfgPduCapacity, 24'd0);
    write_cfg(CfgTimeoutTicks, 24'd0);
    send_item(OpByte, {SarFirst, 6'h01}, 1'b0);
    send_item(OpByte, 8'h55, 1'b0);
    send_item(OpByte, 8'hAA, 1'b1);
    send_ticks(2);
    settle_idle();
    write_cfg(CfgPduCapacity, 24'd2);
    write_cfg(CfgTimeoutTicks, 24'd3);
    // Timeout in the middle of a fragment; its tail is dropped.
    send_item(OpByte, {SarFirst, 6'h02}, 1'b0);
    send_item(OpByte, 8'h01, 1'b0);
    send_ticks(3);
    send_item(OpByte, 8'h02, 1'b1);
    send_item(OpByte, {SarComplete, 6'h07}, 1'b0);
    send_item(OpByte, 8'hA5, 1'b0);
    send_item(OpByte, 8'h5A, 1'b0);
    send_item(OpByte, 8'hC3, 1'b1);
    send_item(OpByte, {SarFirst, 6'h1F}, 1'b0);
    send_item(OpByte, 8'h01, 1'b0);
    send_item(OpByte, 8'h02, 1'b1);
    send_item(OpByte, {SarCont, 6'h1F}, 1'b0);
    send_item(OpByte, 8'h03, 1'b1);
    send_item(OpByte, {SarLast, 6'h1F}, 1'b0);
    send_item(OpByte, 8'h04, 1'b1);
    settle_idle();
  endtask

  task automatic test_random_traffic(input int nbytes, input logic [15:0] cap,
                                     input logic [23:0] tmo);
    int         goal;
    int         ncont;
    logic [5:0] typ;
    goal = bytes_sent + nbytes;
    write_cfg(CfgPduCapacity, {8'($urandom), cap});
    write_cfg(CfgTimeoutTicks, tmo);
    while (bytes_sent < goal) begin
      typ = 6'($urandom);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          ncont = $urandom_range(0, 3);
          send_fragment({SarFirst, typ}, rand_frag_len());
          repeat (ncont) begin
            send_ticks($urandom_range(0, 2));
            send_fragment({SarCont, typ}, rand_frag_len());
          end
          send_ticks($urandom_range(0, 1));
          send_fragment({SarLast, typ}, rand_frag_len());
        end
        4, 5, 6: send_fragment({SarComplete, typ}, rand_frag_len());
        7: send_fragment(8'($urandom), rand_frag_len());
        8: send_ticks($urandom_range(1, 4));
        default: begin
          // Segmented transfer that is abandoned before its last fragment.
          send_fragment({SarFirst, typ}, rand_frag_len());
          if ($urandom_range(0, 1) == 1) send_fragment({SarCont, typ}, rand_frag_len());
          send_ticks($urandom_range(1, 10));
        end
      endcase
    end
    settle_idle();
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = CfgPduCapacity;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    op_i = OpByte;
    data_i = 8'd0;
    frag_end_i = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_idle_pct = 11;
    recv_idle_pct = 84;
    test_header_checks();
    test_capacity_and_timeout();
    test_random_traffic(75, 16'd65535, 24'hFFFFFF);
    test_random_traffic(75, 16'($urandom_range(1, 12)), 24'($urandom_range(1, 6)));

    send_idle_pct = 84;
    recv_idle_pct = 11;
    test_random_traffic(75, 16'd1, 24'd1);
    test_random_traffic(75, 16'($urandom_range(1, 12)), 24'($urandom_range(2, 10)));

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(75, 16'd4, TimeoutTicksReset);
    test_random_traffic(75, 16'($urandom_range(1, 12)), 24'($urandom_range(1, 8)));

    if (mismatches == 0 && results_due.size() == 0) begin
      $display("PASS mesh_proxy_sar_reassembler_core");
    end else begin
      $display("FAIL mesh_proxy_sar_reassembler_core");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/msr_pkg.sv
rtl/msr_step.sv
rtl/msr_out_fifo.sv
rtl/mesh_proxy_sar_reassembler_core.sv
sim/mesh_proxy_sar_reassembler_core_test.sv
